[hw/rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   // Operation codes carried in the request
   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int TAG_W  = 32;
   localparam int AGE_W  = 8;
   localparam int PRIO_W = 2;
   localparam int OUT_COUNT_W = 5;

   localparam int REQ_DATA_W = 48;  // 44 bits of fields, padded to whole bytes
   localparam int RSP_DATA_W = 56;  // 50 bits of fields, padded to whole bytes

   // One stored entry
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [AGE_W-1:0]  age;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic      insert;   // push into a non-full queue
      logic      remove;   // pop from a non-empty queue
      entry_type entry;    // entry being pushed
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/stable_priority_queue.sv]
`default_nettype none

// Stable priority queue of up to CAPACITY entries (tag, age, priority), kept
// sorted in a row of cells, lowest priority number at the head and equal
// priorities in arrival order. Each request (push, pop, clear, or no-op for
// action 3) yields exactly one response, registered and shown on the cycle
// after the request transfer. One request is taken every cycle while the
// response side keeps up: every cell compares its own priority with the
// pushed one and shifts toward its neighbor in the same cycle, so the rate is
// one item per clock regardless of fill level. A push into a full queue is
// dropped with status full; a pop or clear on an empty queue reports empty.
// No clearing pass is needed after reset.
module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // action[1:0], entry_tag[33:2], entry_age[41:34], entry_priority[43:42]
   input  wire logic [spq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // status_code[1:0], removed_valid[2], removed_tag[34:3], removed_age[42:35],
   // removed_priority[44:43], entry_count[49:45]
   output logic [spq_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   spq_pkg::action_type    req_action;
   spq_pkg::entry_type     req_entry;
   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::status_type    status;
   logic                   accept;
   logic                   empty;
   logic                   full;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic [CNT_W+spq_pkg::OUT_COUNT_W-1:0] count_wide;

   spq_pkg::entry_type cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_after;
   logic [CAPACITY-1:0] occupied;
   spq_pkg::entry_type removed;
   logic               removed_valid;

   // Request unpacking
   assign req_action    = spq_pkg::action_type'(req_tdata[1:0]);
   assign req_entry.tag  = req_tdata[33:2];
   assign req_entry.age  = req_tdata[41:34];
   assign req_entry.prio = req_tdata[43:42];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(CAPACITY));

   // Command to the cell row
   always_comb begin
      ctrl.entry  = req_entry;
      ctrl.insert = accept && (req_action == spq_pkg::ACT_PUSH) && !full;
      ctrl.remove = accept && (req_action == spq_pkg::ACT_POP) && !empty;
   end

   // Cell row
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      spq_pkg::entry_type prev_entry;
      spq_pkg::entry_type next_entry;
      logic               prev_after;

      assign occupied[gi] = (count_ff > CNT_W'(gi));

      if (gi == 0) begin : g_head
         assign prev_entry = req_entry;
         assign prev_after = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[gi-1];
         assign prev_after = cell_after[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
         assign next_entry = cell_entry[gi];
      end else begin : g_inner
         assign next_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied[gi]),
         .prev_entry (prev_entry),
         .prev_after (prev_after),
         .next_entry (next_entry),
         .entry      (cell_entry[gi]),
         .after      (cell_after[gi])
      );
   end

   // Count update and status
   always_comb begin
      count_in = count_ff;
      status   = spq_pkg::ST_DONE;
      unique case (req_action)
         spq_pkg::ACT_PUSH: begin
            if (full) begin
               status = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         spq_pkg::ACT_POP: begin
            if (empty) begin
               status = spq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         spq_pkg::ACT_CLEAR: begin
            if (empty) begin
               status = spq_pkg::ST_EMPTY;
            end else begin
               count_in = '0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Response assembly, removed-entry fields zero unless a pop removed an entry
   always_comb begin
      removed_valid = (req_action == spq_pkg::ACT_POP) && !empty;
      removed       = removed_valid ? cell_entry[0] : '0;
      count_wide    = {{spq_pkg::OUT_COUNT_W{1'b0}}, count_in};
      rsp_data_in   = '0;
      rsp_data_in[1:0]   = status;
      rsp_data_in[2]     = removed_valid;
      rsp_data_in[34:3]  = removed.tag;
      rsp_data_in[42:35] = removed.age;
      rsp_data_in[44:43] = removed.prio;
      rsp_data_in[49:45] = count_wide[spq_pkg::OUT_COUNT_W-1:0];
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/spq_cell.sv]
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic                  occupied,    // slot holds a live entry
   input  wire spq_pkg::entry_type    prev_entry,  // neighbor toward the head
   input  wire logic                  prev_after,  // new entry goes after prev slot
   input  wire spq_pkg::entry_type    next_entry,  // neighbor toward the tail
   output spq_pkg::entry_type         entry,
   output logic                       after        // new entry goes after this slot
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Stable order: the new entry passes every stored entry of equal or smaller priority
   assign after = occupied && (entry_ff.prio <= ctrl.entry.prio);
   assign entry = entry_ff;

   // Local insert / shift decision
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !after) begin
         entry_in = prev_after ? ctrl.entry : prev_entry;
      end else if (ctrl.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;

   // Expected response, one per request
   typedef struct packed {
      spq_pkg::status_type        status;
      logic                       removed;
      logic [spq_pkg::TAG_W-1:0]  tag;
      logic [spq_pkg::AGE_W-1:0]  age;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [4:0]                 count;
   } queue_result_type;

   // Sorted-queue predictor plus the list of responses still owed
   class queue_scoreboard;
      spq_pkg::entry_type slots[QUEUE_DEPTH];
      int unsigned        stored;
      queue_result_type   owed_q[$];
      int                 errors;

      function new();
         stored = 0;
         errors = 0;
      endfunction

      // Apply one accepted request to the shadow queue
      function void note_request(spq_pkg::action_type act, logic [spq_pkg::TAG_W-1:0] tag,
                                 logic [spq_pkg::AGE_W-1:0] age,
                                 logic [spq_pkg::PRIO_W-1:0] prio);
         queue_result_type r;
         int unsigned      pos;
         r = '0;
         r.status = spq_pkg::ST_DONE;
         case (act)
            spq_pkg::ACT_PUSH: begin
               if (stored >= QUEUE_DEPTH) begin
                  r.status = spq_pkg::ST_FULL;
               end else begin
                  // land behind every entry of equal or better priority
                  pos = 0;
                  while (pos < stored && slots[pos].prio <= prio) pos++;
                  for (int k = stored; k > pos; k--) slots[k] = slots[k-1];
                  slots[pos].tag  = tag;
                  slots[pos].age  = age;
                  slots[pos].prio = prio;
                  stored++;
               end
            end
            spq_pkg::ACT_POP: begin
               if (stored == 0) begin
                  r.status = spq_pkg::ST_EMPTY;
               end else begin
                  r.removed = 1'b1;
                  r.tag     = slots[0].tag;
                  r.age     = slots[0].age;
                  r.prio    = slots[0].prio;
                  for (int k = 1; k < stored; k++) slots[k-1] = slots[k];
                  stored--;
               end
            end
            spq_pkg::ACT_CLEAR: begin
               if (stored == 0) r.status = spq_pkg::ST_EMPTY;
               else stored = 0;
            end
            default: ;
         endcase
         r.count = 5'(stored);
         owed_q.push_back(r);
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
            errors++;
         end
      endfunction

      // Compare one response transfer with the oldest owed result
      function void check_result(logic [spq_pkg::RSP_DATA_W-1:0] d);
         queue_result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, d);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         compare_field("status_code", want.status, d[1:0]);
         compare_field("removed_valid", want.removed, d[2]);
         compare_field("removed_tag", want.tag, d[34:3]);
         compare_field("removed_age", want.age, d[42:35]);
         compare_field("removed_priority", want.prio, d[44:43]);
         compare_field("entry_count", want.count, d[49:45]);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // action[1:0], entry_tag[33:2], entry_age[41:34], entry_priority[43:42]
   logic [spq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // status_code[1:0], removed_valid[2], removed_tag[34:3], removed_age[42:35],
   // removed_priority[44:43], entry_count[49:45]
   logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata;

   queue_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   stable_priority_queue #(.CAPACITY(QUEUE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // One request transfer, with random idle cycles ahead of it
   task automatic send_req(spq_pkg::action_type act, logic [spq_pkg::TAG_W-1:0] tag,
                           logic [spq_pkg::AGE_W-1:0] age,
                           logic [spq_pkg::PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, prio, age, tag, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, tag, age, prio);
   endtask

   // Stop offering and wait until every owed response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Random priority, mostly 1..3 so equal priorities are common
   function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
      if ($urandom_range(9) == 0) return 2'd0;
      return spq_pkg::PRIO_W'($urandom_range(3, 1));
   endfunction

   // Random traffic; the push share swings so the queue fills and empties
   task automatic run_random(int n);
      int                  push_pct;
      int                  roll;
      spq_pkg::action_type act;
      push_pct = 50;
      for (int i = 0; i < n; i++) begin
         if (i % 24 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 80;
               1:       push_pct = 50;
               default: push_pct = 20;
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 3) act = spq_pkg::ACT_CLEAR;
         else if (roll < 6) act = spq_pkg::ACT_NOP;
         else if (roll < 6 + push_pct * 94 / 100) act = spq_pkg::ACT_PUSH;
         else act = spq_pkg::ACT_POP;
         send_req(act, $urandom, spq_pkg::AGE_W'($urandom_range(255)), pick_prio());
      end
   endtask

   initial begin
      logic [spq_pkg::PRIO_W-1:0] prio_seq [16];
      sb = new();
      prio_seq = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1,
                   2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, fill past full with mixed priorities, then empty again
      send_req(spq_pkg::ACT_POP, '0, '0, 2'd1);
      send_req(spq_pkg::ACT_CLEAR, '0, '0, 2'd1);
      send_req(spq_pkg::ACT_NOP, 32'hFFFF_FFFF, 8'hFF, 2'd3);
      for (int i = 0; i < 16; i++) begin
         send_req(spq_pkg::ACT_PUSH, (i % 2 == 0) ? 32'hFFFF_FFFF - i : 32'(i),
                  spq_pkg::AGE_W'(i * 17), prio_seq[i]);
      end
      send_req(spq_pkg::ACT_PUSH, 32'hA5A5_5A5A, 8'h80, 2'd2);
      send_req(spq_pkg::ACT_NOP, '0, '0, 2'd0);
      send_req(spq_pkg::ACT_POP, '0, '0, 2'd0);
      send_req(spq_pkg::ACT_CLEAR, '0, '0, 2'd0);
      send_req(spq_pkg::ACT_POP, '0, '0, 2'd0);
      drain();

      // Sender slow-ish, receiver slower
      send_idle_pct = 33;
      recv_idle_pct = 61;
      run_random(280);
      drain();

      // Roles swapped
      send_idle_pct = 61;
      recv_idle_pct = 33;
      run_random(280);
      drain();

      // No idling; first a long response hold-off while pushes keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 100;
      for (int i = 0; i < 30; i++) begin
         send_req(spq_pkg::ACT_PUSH, $urandom, spq_pkg::AGE_W'($urandom_range(255)),
                  pick_prio());
      end
      drain();
      run_random(260);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
